/* hw/rtl/pri_pkg.sv */
// Shared types and constants for the pointer registry hash index.
// Used by pri_hash, pri_ram users and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package pri_pkg;

    localparam int ENTRIES = 256;
    localparam int BUCKETS = 1024;
    localparam int EIW     = $clog2(ENTRIES);
    localparam int CW      = $clog2(ENTRIES + 1);
    localparam int BW      = $clog2(BUCKETS);
    localparam int CAP     = (ENTRIES < BUCKETS) ? ENTRIES : BUCKETS;

    // Murmur finalizer multipliers.
    localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
    localparam int MIX_SHIFT = 33;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_LOOKUP = 3'd1;
    localparam logic [2:0] CMD_MARK   = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_SWEEP  = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NULL      = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] key;
        logic [31:0] size_bytes;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  entry_pos;
        logic [31:0] found_size;
        logic        was_marked;
        logic [8:0]  freed_count;
        logic [8:0]  live_count;
    } response_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_KEY_CHK,
        S_CLEAR,
        S_SWEEP_RD,
        S_SWEEP_WR,
        S_WIPE,
        S_RB_RD,
        S_RB_HASH
    } state_t;

endpackage
`default_nettype wire

/* hw/rtl/pri_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package needed.
`timescale 1ns / 1ps
`default_nettype none
module pri_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* hw/rtl/pri_hash.sv */
// Multi-cycle murmur fmix64 unit giving the home bucket of a key.
// Depends on pri_pkg; uses one shared 32x32 multiplier over nine steps.
`timescale 1ns / 1ps
`default_nettype none
module pri_hash (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [63:0]         key,
    output logic                     done,
    output logic [pri_pkg::BW-1:0]   bucket
);
    import pri_pkg::*;

    localparam logic [3:0] STEP_IDLE = 4'd0;
    localparam logic [3:0] STEP_LAST = 4'd8;
    localparam logic [3:0] STEP_DONE = 4'd9;

    logic [3:0]  step_reg, step_next;
    logic [63:0] h_reg, h_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] mul_c;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    // Operand selection for the shared multiplier: low-low, low-high, high-low.
    always_comb
    begin
        mul_c = (step_reg > 4'd4) ? MIX_C2 : MIX_C1;
        mul_a = (step_reg[1:0] == 2'd3) ? h_reg[63:32] : h_reg[31:0];
        mul_b = (step_reg[1:0] == 2'd2) ? mul_c[63:32] : mul_c[31:0];
        prod  = 64'(mul_a) * 64'(mul_b);
    end

    // Step sequencer: mix, then two multiply rounds each closed by a xor-shift.
    always_comb
    begin
        step_next = step_reg;
        h_next    = h_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            h_next    = key ^ (key >> MIX_SHIFT);
            step_next = 4'd1;
        end
        else if (step_reg == STEP_DONE)
        begin
            step_next = STEP_IDLE;
        end
        else if (step_reg != STEP_IDLE)
        begin
            unique case (step_reg[1:0])
                2'd1:    acc_next = prod;
                2'd2:    acc_next = acc_reg + {prod[31:0], 32'b0};
                2'd3:    acc_next = acc_reg + {prod[31:0], 32'b0};
                default: h_next   = acc_reg ^ (acc_reg >> MIX_SHIFT);
            endcase
            step_next = (step_reg == STEP_LAST) ? STEP_DONE : step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg   <= h_next;
        acc_reg <= acc_next;
    end

    assign done   = (step_reg == STEP_DONE);
    assign bucket = h_reg[BW-1:0];

endmodule
`default_nettype wire

/* hw/rtl/pointer_registry_hash_index.sv */
// Pointer registry top level: command sequencer, entry and bucket memories.
// Depends on pri_pkg, pri_ram and pri_hash.
//
// Commands are taken when start is high and busy is low; each command gives
// exactly one response word, shown for one cycle with done high, and the
// receiver cannot stall it. After reset the block clears its 1024-slot bucket
// memory, one slot a cycle, and holds busy high while it does so. Insert,
// lookup and mark run the key through the nine-step hash unit, then probe
// the buckets through the registered read ports of the memories. Clear marks
// clears one live entry per cycle. Sweep reads each live entry and moves
// survivors down, clears the buckets one slot a cycle, then rehashes and
// reinserts each surviving entry.
`timescale 1ns / 1ps
`default_nettype none
module pointer_registry_hash_index (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire pri_pkg::request_t  request,
    output logic                    done,
    output pri_pkg::response_t      response
);
    import pri_pkg::*;

    state_t          state_reg, state_next;
    request_t        req_reg, req_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   r_reg, r_next;
    logic [CW-1:0]   w_reg, w_next;
    logic [CW-1:0]   rec_reg, rec_next;
    logic [CW-1:0]   ent_reg, ent_next;
    logic [CW-1:0]   slot_reg, slot_next;
    logic [BW-1:0]   b_reg, b_next;
    logic [BW:0]     n_reg, n_next;
    logic [BW:0]     clr_reg, clr_next;
    logic            place_reg, place_next;
    logic            rb_reg, rb_next;
    logic            done_reg, done_next;
    response_t       resp_reg, resp_next;

    logic            key_we, size_we, mark_we, bkt_we;
    logic [EIW-1:0]  ent_waddr, ent_raddr;
    logic [63:0]     key_wdata, key_rdata;
    logic [31:0]     size_wdata, size_rdata;
    logic            mark_wdata, mark_rdata;
    logic [BW-1:0]   bkt_waddr, bkt_raddr;
    logic [CW-1:0]   bkt_wdata, bkt_rdata;

    logic            hash_start, hash_done;
    logic [63:0]     hash_key;
    logic [BW-1:0]   hash_bucket;

    pri_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_keys (
        .clk(clk), .we(key_we), .waddr(ent_waddr), .wdata(key_wdata),
        .raddr(ent_raddr), .rdata(key_rdata)
    );
    pri_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_sizes (
        .clk(clk), .we(size_we), .waddr(ent_waddr), .wdata(size_wdata),
        .raddr(ent_raddr), .rdata(size_rdata)
    );
    pri_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_marks (
        .clk(clk), .we(mark_we), .waddr(ent_waddr), .wdata(mark_wdata),
        .raddr(ent_raddr), .rdata(mark_rdata)
    );
    pri_ram #(.WIDTH(CW), .DEPTH(BUCKETS)) u_buckets (
        .clk(clk), .we(bkt_we), .waddr(bkt_waddr), .wdata(bkt_wdata),
        .raddr(bkt_raddr), .rdata(bkt_rdata)
    );

    pri_hash u_hash (
        .clk(clk), .rst_n(rst_n), .start(hash_start), .key(hash_key),
        .done(hash_done), .bucket(hash_bucket)
    );

    // Command sequencer: next state, memory controls and the response word.
    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        count_next = count_reg;
        r_next     = r_reg;
        w_next     = w_reg;
        rec_next   = rec_reg;
        ent_next   = ent_reg;
        slot_next  = slot_reg;
        b_next     = b_reg;
        n_next     = n_reg;
        clr_next   = clr_reg;
        place_next = place_reg;
        rb_next    = rb_reg;
        done_next  = 1'b0;
        resp_next  = resp_reg;

        key_we     = 1'b0;
        size_we    = 1'b0;
        mark_we    = 1'b0;
        bkt_we     = 1'b0;
        ent_waddr  = r_reg[EIW-1:0];
        ent_raddr  = r_reg[EIW-1:0];
        key_wdata  = key_rdata;
        size_wdata = size_rdata;
        mark_wdata = 1'b0;
        bkt_waddr  = clr_reg[BW-1:0];
        bkt_wdata  = '0;
        bkt_raddr  = b_reg;
        hash_start = 1'b0;
        hash_key   = req_reg.key;

        unique case (state_reg)
            S_INIT:
            begin
                bkt_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (BW + 1)'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    req_next  = request;
                    resp_next = '0;
                    rb_next   = 1'b0;
                    hash_key  = request.key;
                    unique case (request.command)
                        CMD_INSERT:
                        begin
                            if (request.key == '0)
                            begin
                                resp_next.status = ST_NULL;
                                done_next        = 1'b1;
                            end
                            else if (count_reg >= CW'(CAP))
                            begin
                                resp_next.status = ST_FULL;
                                done_next        = 1'b1;
                            end
                            else
                            begin
                                key_we     = 1'b1;
                                size_we    = 1'b1;
                                mark_we    = 1'b1;
                                ent_waddr  = count_reg[EIW-1:0];
                                key_wdata  = request.key;
                                size_wdata = request.size_bytes;
                                ent_next   = count_reg;
                                count_next = count_reg + 1'b1;
                                place_next = 1'b1;
                                hash_start = 1'b1;
                                state_next = S_HASH;
                            end
                        end
                        CMD_LOOKUP, CMD_MARK:
                        begin
                            if (request.key == '0)
                            begin
                                resp_next.status = ST_NULL;
                                done_next        = 1'b1;
                            end
                            else
                            begin
                                place_next = 1'b0;
                                hash_start = 1'b1;
                                state_next = S_HASH;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            r_next = '0;
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_CLEAR;
                            end
                        end
                        CMD_SWEEP:
                        begin
                            r_next   = '0;
                            w_next   = '0;
                            rec_next = '0;
                            clr_next = '0;
                            state_next = (count_reg == '0) ? S_WIPE : S_SWEEP_RD;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_HASH:
            begin
                if (hash_done)
                begin
                    b_next     = hash_bucket;
                    n_next     = '0;
                    state_next = S_PROBE_RD;
                end
            end

            S_PROBE_RD:
            begin
                bkt_raddr  = b_reg;
                state_next = S_PROBE_CHK;
            end

            S_PROBE_CHK:
            begin
                if (place_reg)
                begin
                    if (bkt_rdata == '0)
                    begin
                        bkt_we    = 1'b1;
                        bkt_waddr = b_reg;
                        bkt_wdata = ent_reg + 1'b1;
                        if (rb_reg)
                        begin
                            r_next = r_reg + 1'b1;
                            if (r_reg + 1'b1 == count_reg)
                            begin
                                resp_next.freed_count = 9'(rec_reg);
                                done_next  = 1'b1;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                state_next = S_RB_RD;
                            end
                        end
                        else
                        begin
                            resp_next.entry_pos  = 8'(ent_reg);
                            resp_next.found_size = req_reg.size_bytes;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        b_next     = b_reg + 1'b1;
                        state_next = S_PROBE_RD;
                    end
                end
                else if (bkt_rdata == '0 || bkt_rdata > count_reg)
                begin
                    resp_next.status = ST_NOT_FOUND;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    slot_next  = bkt_rdata;
                    ent_raddr  = EIW'(bkt_rdata - 1'b1);
                    state_next = S_KEY_CHK;
                end
            end

            S_KEY_CHK:
            begin
                if (key_rdata == req_reg.key)
                begin
                    resp_next.entry_pos  = 8'(slot_reg - 1'b1);
                    resp_next.found_size = size_rdata;
                    resp_next.was_marked = mark_rdata;
                    if (req_reg.command == CMD_MARK)
                    begin
                        mark_we    = 1'b1;
                        ent_waddr  = EIW'(slot_reg - 1'b1);
                        mark_wdata = 1'b1;
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (n_reg + 1'b1 == (BW + 1)'(BUCKETS))
                begin
                    resp_next.status = ST_NOT_FOUND;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    n_next     = n_reg + 1'b1;
                    b_next     = b_reg + 1'b1;
                    state_next = S_PROBE_RD;
                end
            end

            S_CLEAR:
            begin
                mark_we = 1'b1;
                r_next  = r_reg + 1'b1;
                if (r_reg + 1'b1 == count_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_SWEEP_RD:
            begin
                state_next = S_SWEEP_WR;
            end

            // Survivors move down to the write pointer with their marks cleared.
            S_SWEEP_WR:
            begin
                if (mark_rdata)
                begin
                    key_we    = 1'b1;
                    size_we   = 1'b1;
                    mark_we   = 1'b1;
                    ent_waddr = w_reg[EIW-1:0];
                    w_next    = w_reg + 1'b1;
                end
                else
                begin
                    rec_next = rec_reg + 1'b1;
                end
                r_next     = r_reg + 1'b1;
                state_next = (r_reg + 1'b1 == count_reg) ? S_WIPE : S_SWEEP_RD;
            end

            S_WIPE:
            begin
                bkt_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (BW + 1)'(BUCKETS - 1))
                begin
                    count_next = w_reg;
                    r_next     = '0;
                    if (w_reg == '0)
                    begin
                        resp_next.freed_count = 9'(rec_reg);
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_RB_RD;
                    end
                end
            end

            S_RB_RD:
            begin
                state_next = S_RB_HASH;
            end

            S_RB_HASH:
            begin
                hash_key   = key_rdata;
                hash_start = 1'b1;
                ent_next   = r_reg;
                place_next = 1'b1;
                rb_next    = 1'b1;
                state_next = S_HASH;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        resp_next.live_count = 9'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            count_reg <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        r_reg     <= r_next;
        w_reg     <= w_next;
        rec_reg   <= rec_next;
        ent_reg   <= ent_next;
        slot_reg  <= slot_next;
        b_reg     <= b_next;
        n_reg     <= n_next;
        place_reg <= place_next;
        rb_reg    <= rb_next;
        resp_reg  <= resp_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign response = resp_reg;

    // A response word always comes with the sequencer back in idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("response word while sequencer busy");

    // An accepted command either starts work or answers in the next cycle.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted command was dropped");

    // The live count never exceeds the capacity.
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> response.live_count <= 9'(CAP))
        else $error("live count above capacity");

    // A full status is only given when the registry is at capacity.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && response.status == ST_FULL |-> response.live_count == 9'(CAP))
        else $error("full status below capacity");

endmodule
`default_nettype wire
